// ----- hdl/cmp_pkg.sv -----
// cmp_pkg: shared types and constants of the column mean projection core.
// Used by cmp_accum, cmp_divider and column_mean_projection_core.
package cmp_pkg;

   localparam int PIX_W    = 16;   // pixel and min/max width
   localparam int SLICE_W  = 12;   // slice number and output row width
   localparam int COLOUT_W = 12;   // column field width on the result channel
   localparam int CFG_W    = 13;   // configuration register width
   localparam int CSR_IDX_W = 2;

   // saturation limits of the projection value
   localparam int SAT_HI      = 16383;
   localparam int SAT_NEG_MAG = 32768;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // side fields that travel with a column sum through the divider
   typedef struct packed {
      logic [COLOUT_W-1:0]     column;
      logic [SLICE_W-1:0]      projection_row;
      logic signed [PIX_W-1:0] running_min;
      logic signed [PIX_W-1:0] running_max;
      logic                    last_of_slice;
   } cmp_meta_type;

   // finished result from the divider
   typedef struct packed {
      cmp_meta_type            meta;
      logic signed [PIX_W-1:0] projection_value;
   } cmp_result_type;

endpackage

// ----- hdl/column_mean_projection_core.sv -----
// column_mean_projection_core: top level of the column mean projection.
// Holds the configuration registers and the result register.
// Depends on cmp_pkg, cmp_accum and cmp_divider.
//
// Usage:
//  - Request channel (req_valid/req_stall, req_pixel, req_slice_number) takes the
//    pixels of a slice in row-major order. Every pixel updates its column sum in
//    a 4096-entry memory (read, add, write back) and the running min and max.
//  - A pixel of the last row yields one result on the rsp_ channel: the column,
//    the output row, twice the column mean (truncated, saturated), min, max and
//    a flag on the final column of the slice. Other pixels yield nothing.
//  - Pixels of the other rows are taken one per cycle while no last-row pixel waits
//    for the divider. A last-row pixel ties up the shared divider, which settles
//    one quotient bit a cycle.
//  - Configuration (csr_write_en, csr_index, csr_data) is to be written by the user
//    only while idle; the block itself does not enforce this.
//  - Reset clears the raster position to zero, min to 32767 and max to -32768;
//    column sums are not cleared, the first row of each slice overwrites them.
//  - While rsp_stall is high the result register holds and the divider waits;
//    requests keep flowing until the next last-row pixel needs the divider.
module column_mean_projection_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cmp_pkg::PIX_W-1:0]      req_pixel,
   input  logic [cmp_pkg::SLICE_W-1:0]           req_slice_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cmp_pkg::COLOUT_W-1:0]          rsp_column,
   output logic [cmp_pkg::SLICE_W-1:0]           rsp_projection_row,
   output logic signed [cmp_pkg::PIX_W-1:0]      rsp_projection_value,
   output logic signed [cmp_pkg::PIX_W-1:0]      rsp_running_min,
   output logic signed [cmp_pkg::PIX_W-1:0]      rsp_running_max,
   output logic                                  rsp_last_of_slice,
   input  logic                                  csr_write_en,
   input  logic [cmp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cmp_pkg::CFG_W-1:0]             csr_data
);
   import cmp_pkg::*;

   localparam int WPOS_W = $clog2(MAX_WIDTH + 1);
   localparam int HPOS_W = $clog2(MAX_HEIGHT + 1);
   localparam int SUM_W  = 16 + $clog2(MAX_HEIGHT);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CFG_W-1:0] slices_ff, slices_in;

   logic [WPOS_W-1:0] width_eff;
   logic [HPOS_W-1:0] height_eff;

   logic                    div_ready;
   logic                    div_start;
   logic signed [SUM_W:0]   div_dividend;
   cmp_meta_type            div_meta;
   logic                    res_valid;
   logic                    res_take;
   cmp_result_type          result;

   logic           rsp_valid_ff, rsp_valid_in;
   cmp_result_type rsp_data_ff;

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      slices_in = slices_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            CSR_SLICE_COUNT:  slices_in = csr_data;
            default: ;
         endcase
      end
   end

   // sizes forced into 1..max
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WPOS_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WPOS_W'(MAX_WIDTH);
      end else begin
         width_eff = WPOS_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HPOS_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HPOS_W'(MAX_HEIGHT);
      end else begin
         height_eff = HPOS_W'(height_ff);
      end
   end

   cmp_accum #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_slice_number (req_slice_number),
      .width_eff        (width_eff),
      .height_eff       (height_eff),
      .slice_count      (slices_ff),
      .div_ready        (div_ready),
      .div_start        (div_start),
      .div_dividend     (div_dividend),
      .div_meta         (div_meta)
   );

   cmp_divider #(
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (height_eff),
      .meta      (div_meta),
      .ready     (div_ready),
      .res_valid (res_valid),
      .res_take  (res_take),
      .result    (result)
   );

   // result register: loads when empty or being drained
   always_comb begin
      res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= CFG_W'(512);
         height_ff    <= CFG_W'(512);
         slices_ff    <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         slices_ff    <= slices_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_column           = rsp_data_ff.meta.column;
   assign rsp_projection_row   = rsp_data_ff.meta.projection_row;
   assign rsp_projection_value = rsp_data_ff.projection_value;
   assign rsp_running_min      = rsp_data_ff.meta.running_min;
   assign rsp_running_max      = rsp_data_ff.meta.running_max;
   assign rsp_last_of_slice    = rsp_data_ff.meta.last_of_slice;

   // a waiting result is never overwritten by the divider
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_take |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

// ----- hdl/cmp_divider.sv -----
// cmp_divider: shared restoring divider, one quotient bit per cycle, with saturation.
// Depends on cmp_pkg.
module cmp_divider #(
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic signed [16+$clog2(MAX_HEIGHT):0]               dividend,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]                     divisor,
   input  cmp_pkg::cmp_meta_type                               meta,
   output logic                                                ready,
   output logic                                                res_valid,
   input  logic                                                res_take,
   output cmp_pkg::cmp_result_type                             result
);
   import cmp_pkg::*;

   localparam int SUM_W  = 16 + $clog2(MAX_HEIGHT);
   localparam int MAG_W  = SUM_W + 1;
   localparam int HPOS_W = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W  = $clog2(MAG_W);

   div_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  dvd_ff, dvd_in;
   logic [HPOS_W-1:0] rem_ff, rem_in;
   logic              neg_ff, neg_in;
   cmp_meta_type      meta_ff, meta_in;

   logic [HPOS_W:0]   rem_sh;
   logic              rem_ge;
   logic [MAG_W-1:0]  mag;
   logic [PIX_W-1:0]  sat_value;

   // magnitude of the signed dividend
   assign mag = dividend[MAG_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[MAG_W-1]};
      rem_ge = rem_sh >= {1'b0, divisor};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN:  if (cnt_ff == '0) state_in = DIV_DONE;
         DIV_DONE: if (res_take) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      meta_in = meta_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               cnt_in  = CNT_W'(MAG_W - 1);
               dvd_in  = mag;
               rem_in  = '0;
               neg_in  = dividend[MAG_W-1];
               meta_in = meta;
            end
         end
         DIV_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            rem_in = rem_ge ? HPOS_W'(rem_sh - {1'b0, divisor}) : HPOS_W'(rem_sh);
            dvd_in = {dvd_ff[MAG_W-2:0], rem_ge};
         end
         default: ;
      endcase
   end

   // sign restore and saturation of the finished quotient
   always_comb begin
      if (!neg_ff) begin
         sat_value = (dvd_ff > MAG_W'(SAT_HI)) ? PIX_W'(SAT_HI) : dvd_ff[PIX_W-1:0];
      end else begin
         sat_value = (dvd_ff > MAG_W'(SAT_NEG_MAG)) ? PIX_W'(SAT_NEG_MAG)
                                                    : PIX_W'(-dvd_ff);
      end
   end

   // outputs
   always_comb begin
      ready                   = (state_ff == DIV_IDLE);
      res_valid               = (state_ff == DIV_DONE);
      result.meta             = meta_ff;
      result.projection_value = sat_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      meta_ff <= meta_in;
   end

   // last step always lands in the done state
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN && cnt_ff == '0) |=> (state_ff == DIV_DONE))
      else $error("divider did not finish after last step");

   // a finished quotient is held until it is taken
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_DONE && !res_take) |=> (state_ff == DIV_DONE && $stable(dvd_ff)))
      else $error("divider result changed before it was taken");

endmodule

// ----- hdl/cmp_accum.sv -----
// cmp_accum: raster position, running min/max and the column sum memory
// (read, add, write back with forwarding). Depends on cmp_pkg.
module cmp_accum #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cmp_pkg::PIX_W-1:0]       req_pixel,
   input  logic [cmp_pkg::SLICE_W-1:0]            req_slice_number,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        height_eff,
   input  logic [cmp_pkg::CFG_W-1:0]              slice_count,
   input  logic                                   div_ready,
   output logic                                   div_start,
   output logic signed [16+$clog2(MAX_HEIGHT):0]  div_dividend,
   output cmp_pkg::cmp_meta_type                  div_meta
);
   import cmp_pkg::*;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WPOS_W = $clog2(MAX_WIDTH + 1);
   localparam int HPOS_W = $clog2(MAX_HEIGHT + 1);
   localparam int SUM_W  = 16 + $clog2(MAX_HEIGHT);

   // column sum memory
   logic signed [SUM_W-1:0] sum_mem [MAX_WIDTH];
   logic signed [SUM_W-1:0] rd_data_ff;
   logic [COL_W-1:0]        rd_addr;

   // raster position and running extremes
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic signed [PIX_W-1:0] min_ff, min_in;
   logic signed [PIX_W-1:0] max_ff, max_in;

   // stage holding the request whose sum is being read
   logic                    s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]        s1_col_ff;
   logic                    s1_first_ff;
   logic                    s1_lastrow_ff;
   logic signed [PIX_W-1:0] s1_pixel_ff;
   cmp_meta_type            s1_meta_ff;

   // last write, for forwarding into the following read
   logic                    fwd_valid_ff;
   logic [COL_W-1:0]        fwd_addr_ff;
   logic signed [SUM_W-1:0] fwd_data_ff;

   logic              accept;
   logic              hold;
   logic              advance;
   logic [COL_W-1:0]  col_now;
   logic [ROW_W-1:0]  row_now;
   logic [WPOS_W-1:0] col_inc;
   logic [HPOS_W-1:0] row_inc;
   logic signed [SUM_W-1:0] sum_base;
   logic signed [SUM_W-1:0] sum_new;
   cmp_meta_type      meta_now;

   // handshake and stage control
   assign hold      = s1_valid_ff && s1_lastrow_ff && !div_ready;
   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;
   assign advance   = s1_valid_ff && !hold;

   // position, wrapped when the size was lowered
   always_comb begin
      col_now = (WPOS_W'(col_ff) >= width_eff)  ? '0 : col_ff;
      row_now = (HPOS_W'(row_ff) >= height_eff) ? '0 : row_ff;
      col_inc = WPOS_W'(col_now) + 1'b1;
      row_inc = HPOS_W'(row_now) + 1'b1;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= width_eff) begin
            col_in = '0;
            row_in = (row_inc >= height_eff) ? '0 : ROW_W'(row_inc);
         end else begin
            col_in = COL_W'(col_inc);
            row_in = row_now;
         end
      end
   end

   // running extremes, current pixel included
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (accept) begin
         if (req_pixel < min_ff) min_in = req_pixel;
         if (req_pixel > max_ff) max_in = req_pixel;
      end
   end

   // side fields of a possible result
   always_comb begin
      meta_now.column         = COLOUT_W'(col_now);
      meta_now.projection_row = SLICE_W'(slice_count) - 1'b1 - req_slice_number;
      meta_now.running_min    = min_in;
      meta_now.running_max    = max_in;
      meta_now.last_of_slice  = (WPOS_W'(col_now) == width_eff - 1'b1);
   end

   always_comb begin
      s1_valid_in = accept || hold;
   end

   // sum update with forwarding of the previous write
   always_comb begin
      if (s1_first_ff) begin
         sum_base = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == s1_col_ff) begin
         sum_base = fwd_data_ff;
      end else begin
         sum_base = rd_data_ff;
      end
      sum_new      = sum_base + SUM_W'(s1_pixel_ff);
      div_start    = advance && s1_lastrow_ff;
      div_dividend = {sum_new, 1'b0};
      div_meta     = s1_meta_ff;
      rd_addr      = accept ? col_now : s1_col_ff;
   end

   // memory ports
   always_ff @(posedge clock) begin
      rd_data_ff <= sum_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_mem[s1_col_ff] <= sum_new;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         min_ff       <= PIX_W'(SAT_HI * 2 + 1);
         max_ff       <= PIX_W'(SAT_NEG_MAG);
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= advance;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff     <= col_now;
         s1_first_ff   <= (row_now == '0);
         s1_lastrow_ff <= (HPOS_W'(row_now) == height_eff - 1'b1);
         s1_pixel_ff   <= req_pixel;
         s1_meta_ff    <= meta_now;
      end
      if (advance) begin
         fwd_addr_ff <= s1_col_ff;
         fwd_data_ff <= sum_new;
      end
   end

   // a held request keeps its column for the re-read
   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      hold |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("held request lost its column");

   // the divider is only started when it is free
   a_start_ready: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_ready)
      else $error("divider started while busy");

endmodule
